### hw/rtl/smeu_pkg.sv
// Shared types, sizes and codes for the stack machine execute unit.
package smeu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int RAM_WORDS   = 256;

   localparam int DATA_W      = 32;
   localparam int IP_W        = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SA_W        = $clog2(STACK_DEPTH);
   localparam int RA_W        = $clog2(RAM_WORDS);
   localparam int NUM_GPR     = 4;
   localparam int CSR_IDX_W   = $clog2(NUM_GPR);
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [3:0] OP_PUSH     = 4'd0;
   localparam logic [3:0] OP_ADD      = 4'd1;
   localparam logic [3:0] OP_SUB      = 4'd2;
   localparam logic [3:0] OP_MUL      = 4'd3;
   localparam logic [3:0] OP_DIV      = 4'd4;
   localparam logic [3:0] OP_OUT      = 4'd5;
   localparam logic [3:0] OP_IN       = 4'd6;
   localparam logic [3:0] OP_JMP      = 4'd7;
   localparam logic [3:0] OP_JA       = 4'd8;
   localparam logic [3:0] OP_JB       = 4'd9;
   localparam logic [3:0] OP_JAE      = 4'd10;
   localparam logic [3:0] OP_JBE      = 4'd11;
   localparam logic [3:0] OP_JE       = 4'd12;
   localparam logic [3:0] OP_JNE      = 4'd13;
   localparam logic [3:0] OP_MEMWRITE = 4'd14;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
   localparam logic [2:0] ST_NO_MODE   = 3'd4;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd5;

   typedef struct packed {
      logic [3:0]         opcode;
      logic               use_register;
      logic               use_immediate;
      logic               use_memory;
      logic [2:0]         register_number;
      logic signed [31:0] immediate;
      logic [15:0]        jump_target;
      logic [7:0]         write_address;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        next_ip;
      logic signed [31:0] out_value;
      logic               out_valid;
      logic [6:0]         stack_depth;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       div_start;
   } alu_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              take;
      logic              div_done;
   } alu_res_type;

endpackage

### hw/rtl/smeu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/smeu_alu.sv
// Shared arithmetic unit: add, sub, mul, signed compare and a bit-serial divider.
module smeu_alu
   import smeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_cmd_type       cmd,
   input  logic [DATA_W-1:0] opa,
   input  logic [DATA_W-1:0] opb,
   output alu_res_type       res
);

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   always_comb begin
      mag_a   = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
      mag_b   = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (cmd.div_start) begin
         // dividend is the lower entry (b), divisor the top (a)
         rem_in = '0;
         quo_in = mag_b;
         dvs_in = mag_a;
         neg_in = opa[DATA_W-1] ^ opb[DATA_W-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      res.div_done = done_ff;
      case (cmd.op)
         OP_ADD:  res.value = opb + opa;
         OP_SUB:  res.value = opb - opa;
         OP_MUL:  res.value = DATA_W'(opb * opa);
         OP_DIV:  res.value = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
         default: res.value = '0;
      endcase
      case (cmd.op)
         OP_JA:   res.take = $signed(opa) >  $signed(opb);
         OP_JB:   res.take = $signed(opa) <  $signed(opb);
         OP_JAE:  res.take = $signed(opa) >= $signed(opb);
         OP_JBE:  res.take = $signed(opa) <= $signed(opb);
         OP_JE:   res.take = opa == opb;
         OP_JNE:  res.take = opa != opb;
         default: res.take = 1'b0;
      endcase
   end

endmodule

### hw/rtl/stack_machine_execute_unit.sv
// Stack machine execute unit: sequencer, operand stack, data memory and registers.
// Executes one decoded instruction per request transaction and returns one response.
// After reset the data memory is zeroed by a sweep over all RAM_WORDS (256) words during
// which req_ready stays low; csr writes are taken throughout. After decode, errors found there
// and push/in/jmp/memwrite go to finish, push from memory reads the data memory first, out
// reads the stack top, add/sub/mul, jumps and a divide by zero read both operands and
// pass the ALU state, and div then runs the one-bit-per-cycle 32-step divider in the shared ALU.
// The response is loaded in finish, and the next request is taken once back in idle; a pending
// response does not block acceptance, only the loading of the following one.
module stack_machine_execute_unit
   import smeu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_RD_A   = 4'd3;
   localparam logic [3:0] S_RD_B   = 4'd4;
   localparam logic [3:0] S_ALU    = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_MEM    = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [DATA_W-1:0] arg_ff, arg_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [IP_W-1:0]   pc_ff, pc_in;
   logic [IP_W-1:0]   nip_ff, nip_in;
   logic [2:0]        status_ff, status_in;
   logic [DATA_W-1:0] outv_ff, outv_in;
   logic              outok_ff, outok_in;
   logic [RA_W-1:0]   clr_ff, clr_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] gpr_ff [NUM_GPR];
   logic [DATA_W-1:0] gpr_in [NUM_GPR];

   logic [SP_W-1:0]   sp_m1;
   logic [SP_W-1:0]   sp_m2;
   logic [DATA_W-1:0] gpr_sel;
   logic              accept;

   logic              stk_we;
   logic [SA_W-1:0]   stk_waddr;
   logic [DATA_W-1:0] stk_wdata;
   logic [SA_W-1:0]   stk_raddr;
   logic [DATA_W-1:0] stk_rdata;

   logic              dm_we;
   logic [RA_W-1:0]   dm_waddr;
   logic [DATA_W-1:0] dm_wdata;
   logic [DATA_W-1:0] dm_rdata;

   alu_cmd_type       alu_cmd;
   alu_res_type       alu_res;

   smeu_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   smeu_ram #(.WIDTH(DATA_W), .DEPTH(RAM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (arg_ff[RA_W-1:0]),
      .rd_data (dm_rdata)
   );

   smeu_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (a_ff),
      .opb   (b_ff),
      .res   (alu_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign sp_m1     = sp_ff - SP_W'(1);
   assign sp_m2     = sp_ff - SP_W'(2);
   // register numbers wrap: 0 picks register 4, 5 picks register 1
   assign gpr_sel   = gpr_ff[CSR_IDX_W'(req_data.register_number - 3'd1)];

   always_comb begin
      for (int i = 0; i < NUM_GPR; i++) begin
         gpr_in[i] = gpr_ff[i];
      end
      if (csr_we) begin
         gpr_in[csr_index] = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      arg_in       = arg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sp_in        = sp_ff;
      pc_in        = pc_ff;
      nip_in       = nip_ff;
      status_in    = status_ff;
      outv_in      = outv_ff;
      outok_in     = outok_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      stk_we       = 1'b0;
      stk_waddr    = sp_ff[SA_W-1:0];
      stk_wdata    = arg_ff;
      stk_raddr    = sp_m1[SA_W-1:0];
      dm_we        = 1'b0;
      dm_waddr     = clr_ff;
      dm_wdata     = '0;
      alu_cmd.op        = req_ff.opcode;
      alu_cmd.div_start = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            dm_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RA_W'(RAM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               arg_in    = (req_data.use_register ? gpr_sel : '0) +
                           (req_data.use_immediate ? req_data.immediate : '0);
               status_in = ST_OK;
               outv_in   = '0;
               outok_in  = 1'b0;
               nip_in    = pc_ff + IP_W'(1);
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            case (req_ff.opcode)
               OP_PUSH: begin
                  nip_in = pc_ff + IP_W'(2) + IP_W'(req_ff.use_register)
                           + IP_W'(req_ff.use_immediate);
                  if (!req_ff.use_register && !req_ff.use_immediate &&
                      !req_ff.use_memory) begin
                     status_in = ST_NO_MODE;
                  end else if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     status_in = ST_OVERFLOW;
                  end else if (req_ff.use_memory) begin
                     // unsigned compare also rejects negative addresses
                     if (arg_ff >= DATA_W'(RAM_WORDS)) begin
                        status_in = ST_BAD_ADDR;
                     end else begin
                        state_in = S_MEM;
                     end
                  end else begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SP_W'(1);
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JA, OP_JB, OP_JAE, OP_JBE,
               OP_JE, OP_JNE: begin
                  if (req_ff.opcode inside {[OP_JA:OP_JNE]}) begin
                     nip_in = pc_ff + IP_W'(2);
                  end
                  if (sp_ff < SP_W'(2)) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     state_in = S_RD_A;
                  end
               end
               OP_OUT: begin
                  if (sp_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     state_in = S_RD_A;
                  end
               end
               OP_IN: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = req_ff.immediate;
                     sp_in     = sp_ff + SP_W'(1);
                  end
               end
               OP_JMP: begin
                  nip_in = req_ff.jump_target;
               end
               OP_MEMWRITE: begin
                  nip_in = pc_ff;
                  if (DATA_W'(req_ff.write_address) >= DATA_W'(RAM_WORDS)) begin
                     status_in = ST_BAD_ADDR;
                  end else begin
                     dm_we    = 1'b1;
                     dm_waddr = RA_W'(req_ff.write_address);
                     dm_wdata = req_ff.immediate;
                  end
               end
               default: begin
               end
            endcase
         end

         S_RD_A: begin
            a_in      = stk_rdata;
            stk_raddr = sp_m2[SA_W-1:0];
            if (req_ff.opcode == OP_OUT) begin
               outv_in  = stk_rdata;
               outok_in = 1'b1;
               sp_in    = sp_m1;
               state_in = S_FINISH;
            end else begin
               state_in = S_RD_B;
            end
         end

         S_RD_B: begin
            b_in     = stk_rdata;
            state_in = S_ALU;
         end

         S_ALU: begin
            state_in = S_FINISH;
            if (req_ff.opcode inside {[OP_JA:OP_JNE]}) begin
               sp_in = sp_m2;
               if (alu_res.take) begin
                  nip_in = req_ff.jump_target;
               end
            end else if (req_ff.opcode == OP_DIV) begin
               if (a_ff == '0) begin
                  status_in = ST_DIV_ZERO;
               end else begin
                  alu_cmd.div_start = 1'b1;
                  state_in          = S_DIV;
               end
            end else begin
               stk_we    = 1'b1;
               stk_waddr = sp_m2[SA_W-1:0];
               stk_wdata = alu_res.value;
               sp_in     = sp_m1;
            end
         end

         S_DIV: begin
            if (alu_res.div_done) begin
               stk_we    = 1'b1;
               stk_waddr = sp_m2[SA_W-1:0];
               stk_wdata = alu_res.value;
               sp_in     = sp_m1;
               state_in  = S_FINISH;
            end
         end

         S_MEM: begin
            stk_we    = 1'b1;
            stk_wdata = dm_rdata;
            sp_in     = sp_ff + SP_W'(1);
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status_ff;
               rsp_in.next_ip     = nip_ff;
               rsp_in.out_value   = outv_ff;
               rsp_in.out_valid   = outok_ff;
               rsp_in.stack_depth = 7'(sp_ff);
               rsp_valid_in       = 1'b1;
               pc_in              = nip_ff;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_GPR; i++) begin
            gpr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_GPR; i++) begin
            gpr_ff[i] <= gpr_in[i];
         end
      end
      req_ff    <= req_in;
      arg_ff    <= arg_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      nip_ff    <= nip_in;
      status_ff <= status_in;
      outv_ff   <= outv_in;
      outok_ff  <= outok_in;
      rsp_ff    <= rsp_in;
   end

endmodule

### verif/stack_machine_execute_unit_tb.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 100ps

module testbench;
   import smeu_pkg::*;

   localparam logic [3:0] OP_RESERVED = 4'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_GPR_ONE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GPR_TWO   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GPR_THREE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_GPR_FOUR  = CSR_IDX_W'(3);

   // push argument modes: {use_register, use_immediate, use_memory}
   localparam logic [2:0] M_NONE = 3'b000;
   localparam logic [2:0] M_REG  = 3'b100;
   localparam logic [2:0] M_IMM  = 3'b010;
   localparam logic [2:0] M_MEM  = 3'b001;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   // shadow copy of the machine state
   logic [31:0] gpr_shadow [NUM_GPR];
   logic [31:0] stack_shadow [STACK_DEPTH];
   int          depth_shadow;
   logic [15:0] pc_shadow;
   logic [31:0] ram_shadow [RAM_WORDS];

   rsp_type predicted_results [$];
   rsp_type expected_rsp;
   int      mismatches    = 0;
   int      stall_cycles  = 0;
   int      hold_requests = 0;
   int      hold_served;
   int      hold_left;
   logic    no_idle;

   stack_machine_execute_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Executes one instruction on the shadow state and returns the response it gives.
   function automatic rsp_type execute_instr(input req_type r);
      rsp_type            res;
      logic [31:0]        arg;
      logic [31:0]        a;
      logic [31:0]        b;
      logic [31:0]        val;
      logic [2:0]         rsel;
      logic [15:0]        nxt;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic               take;
      res  = '0;
      nxt  = pc_shadow + 16'd1;
      take = 1'b0;
      case (r.opcode)
         OP_PUSH: begin
            nxt  = pc_shadow + 16'd2 + 16'(r.use_register) + 16'(r.use_immediate);
            rsel = r.register_number - 3'd1;
            arg  = '0;
            if (r.use_register) arg = arg + gpr_shadow[rsel[1:0]];
            if (r.use_immediate) arg = arg + r.immediate;
            if (!r.use_register && !r.use_immediate && !r.use_memory) begin
               res.status = ST_NO_MODE;
            end else if (depth_shadow >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else if (r.use_memory) begin
               if ($signed(arg) < 0 || $signed(arg) >= RAM_WORDS) begin
                  res.status = ST_BAD_ADDR;
               end else begin
                  stack_shadow[depth_shadow] = ram_shadow[arg[RA_W-1:0]];
                  depth_shadow++;
               end
            end else begin
               stack_shadow[depth_shadow] = arg;
               depth_shadow++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (depth_shadow < 2) begin
               res.status = ST_UNDERFLOW;
            end else begin
               a = stack_shadow[depth_shadow-1];
               b = stack_shadow[depth_shadow-2];
               if (r.opcode == OP_DIV && a == '0) begin
                  res.status = ST_DIV_ZERO;
               end else begin
                  case (r.opcode)
                     OP_ADD: val = b + a;
                     OP_SUB: val = b - a;
                     OP_MUL: val = b * a;
                     // most negative over minus one wraps back to itself
                     default: val = (b == 32'h8000_0000 && a == '1) ? b
                                    : 32'($signed(b) / $signed(a));
                  endcase
                  depth_shadow--;
                  stack_shadow[depth_shadow-1] = val;
               end
            end
         end
         OP_OUT: begin
            if (depth_shadow < 1) begin
               res.status = ST_UNDERFLOW;
            end else begin
               depth_shadow--;
               res.out_value = stack_shadow[depth_shadow];
               res.out_valid = 1'b1;
            end
         end
         OP_IN: begin
            if (depth_shadow >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               stack_shadow[depth_shadow] = r.immediate;
               depth_shadow++;
            end
         end
         OP_JMP: nxt = r.jump_target;
         OP_JA, OP_JB, OP_JAE, OP_JBE, OP_JE, OP_JNE: begin
            nxt = pc_shadow + 16'd2;
            if (depth_shadow < 2) begin
               res.status = ST_UNDERFLOW;
            end else begin
               sa = stack_shadow[depth_shadow-1];
               sb = stack_shadow[depth_shadow-2];
               depth_shadow -= 2;
               case (r.opcode)
                  OP_JA:   take = sa > sb;
                  OP_JB:   take = sa < sb;
                  OP_JAE:  take = sa >= sb;
                  OP_JBE:  take = sa <= sb;
                  OP_JE:   take = sa == sb;
                  default: take = sa != sb;
               endcase
               if (take) nxt = r.jump_target;
            end
         end
         OP_MEMWRITE: begin
            nxt = pc_shadow;
            if (r.write_address >= RAM_WORDS) res.status = ST_BAD_ADDR;
            else ram_shadow[r.write_address] = r.immediate;
         end
         default: ;
      endcase
      pc_shadow       = nxt;
      res.next_ip     = nxt;
      res.stack_depth = 7'(depth_shadow);
      return res;
   endfunction

   function automatic req_type mk_instr(input logic [3:0] op, input logic [2:0] mode,
                                        input logic [2:0] rn, input logic [31:0] imm,
                                        input logic [15:0] target, input logic [7:0] waddr);
      req_type r;
      r.opcode          = op;
      {r.use_register, r.use_immediate, r.use_memory} = mode;
      r.register_number = rn;
      r.immediate       = imm;
      r.jump_target     = target;
      r.write_address   = waddr;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: case ($urandom_range(4))
               0: return 32'd0;
               1: return 32'd1;
               2: return '1;
               3: return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         1: return $urandom_range(300);
         2: return 32'($urandom_range(20)) - 32'd10;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_instr();
      req_type r;
      int      pick;
      r.use_register    = 1'($urandom_range(1));
      r.use_immediate   = 1'($urandom_range(1));
      r.use_memory      = 1'($urandom_range(1));
      r.register_number = 3'($urandom_range(7));
      r.immediate       = rand_word();
      r.jump_target     = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 16'hffff : 16'h0)
                                                   : 16'($urandom_range(16'hffff));
      r.write_address   = 8'($urandom_range(255));
      // memory pushes mostly aim inside the data memory
      if (r.use_memory && $urandom_range(3) != 0) r.immediate = $urandom_range(RAM_WORDS - 1);
      pick = $urandom_range(99);
      if (depth_shadow < 2 && $urandom_range(1)) pick = $urandom_range(39);
      if (pick < 30)      r.opcode = OP_PUSH;
      else if (pick < 40) r.opcode = OP_IN;
      else if (pick < 65) r.opcode = 4'(OP_ADD + $urandom_range(3));
      else if (pick < 73) r.opcode = OP_OUT;
      else if (pick < 88) r.opcode = 4'(OP_JA + $urandom_range(5));
      else if (pick < 91) r.opcode = OP_JMP;
      else if (pick < 98) r.opcode = OP_MEMWRITE;
      else                r.opcode = OP_RESERVED;
      return r;
   endfunction

   function automatic req_type operand_instr();
      req_type r;
      r = rand_instr();
      if ($urandom_range(1)) begin
         r.opcode = OP_IN;
      end else begin
         r.opcode = OP_PUSH;
         if (!r.use_register && !r.use_immediate && !r.use_memory) r.use_immediate = 1'b1;
      end
      return r;
   endfunction

   function automatic req_type operator_instr();
      req_type r;
      int      k;
      r = rand_instr();
      k = $urandom_range(10);
      if (k < 4)       r.opcode = 4'(OP_ADD + k);
      else if (k < 10) r.opcode = 4'(OP_JA + (k - 4));
      else             r.opcode = OP_OUT;
      return r;
   endfunction

   task automatic issue_instr(input req_type r);
      int gap;
      gap = 0;
      if (!no_idle) while ($urandom_range(99) < 14) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted_results.push_back(execute_instr(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   task automatic write_gpr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      gpr_shadow[idx] = value;
   endtask

   task automatic load_gprs(input logic [31:0] g1, input logic [31:0] g2,
                            input logic [31:0] g3, input logic [31:0] g4);
      wait_idle();
      repeat (4) @(posedge clock);
      write_gpr(CSR_GPR_ONE, g1);
      write_gpr(CSR_GPR_TWO, g2);
      write_gpr(CSR_GPR_THREE, g3);
      write_gpr(CSR_GPR_FOUR, g4);
      csr_we <= 1'b0;
   endtask

   // Mostly short programs: two operands followed by an operator, mixed with loose items.
   task automatic run_programs(input int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) < 6) begin
            issue_instr(operand_instr());
            issue_instr(operand_instr());
            issue_instr(operator_instr());
            n += 3;
         end else begin
            issue_instr(rand_instr());
            n++;
         end
      end
   endtask

   task automatic test_directed();
      load_gprs(32'd7, 32'd300, 32'h7fff_ffff, 32'h8000_0000);
      issue_instr(mk_instr(OP_PUSH, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_OUT, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_ADD, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_MEMWRITE, M_NONE, 3'd1, 32'hdead_beef, 16'd0, 8'd255));
      issue_instr(mk_instr(OP_MEMWRITE, M_NONE, 3'd1, 32'h1234_5678, 16'd0, 8'd7));
      // address 0 when only memory mode is set
      issue_instr(mk_instr(OP_PUSH, M_MEM, 3'd1, 32'd99, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_REG | M_MEM, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_IMM | M_MEM, 3'd1, 32'd255, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_IMM | M_MEM, 3'd1, 32'd256, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_REG | M_IMM | M_MEM, 3'd3, 32'd1, 16'd0, 8'd0));
      // register numbers out of range wrap onto the four registers
      issue_instr(mk_instr(OP_PUSH, M_REG, 3'd0, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_REG, 3'd5, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_REG | M_IMM, 3'd7, '1, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'h8000_0000, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, '1, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_DIV, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_DIV, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_MUL, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_SUB, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_JA, M_NONE, 3'd1, 32'd0, 16'hffff, 8'd0));
      issue_instr(mk_instr(OP_JB, M_NONE, 3'd1, 32'd0, 16'h0000, 8'd0));
      issue_instr(mk_instr(OP_JAE, M_NONE, 3'd1, 32'd0, 16'h1234, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'd4, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'd4, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_JBE, M_NONE, 3'd1, 32'd0, 16'h00aa, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, -32'sd7, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'd9, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_JNE, M_NONE, 3'd1, 32'd0, 16'h0100, 8'd0));
      issue_instr(mk_instr(OP_JE, M_NONE, 3'd1, 32'd0, 16'h0200, 8'd0));
      issue_instr(mk_instr(OP_JMP, M_NONE, 3'd1, 32'd0, 16'hffff, 8'd0));
      // counter wraps from 0xffff to 0
      issue_instr(mk_instr(OP_RESERVED, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
   endtask

   task automatic test_stack_full();
      while (depth_shadow < STACK_DEPTH)
         issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, rand_word(), 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_REG, 3'd2, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_IN, M_NONE, 3'd1, 32'd5, 16'd0, 8'd0));
      // missing mode wins over overflow, overflow wins over a bad address
      issue_instr(mk_instr(OP_PUSH, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_IMM | M_MEM, 3'd1, -32'sd5, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_OUT, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
      issue_instr(mk_instr(OP_PUSH, M_MEM, 3'd1, 32'd0, 16'd0, 8'd0));
      while (depth_shadow > 0)
         issue_instr(mk_instr(OP_OUT, M_NONE, 3'd1, 32'd0, 16'd0, 8'd0));
   endtask

   task automatic test_random_programs(input int count);
      run_programs(count);
   endtask

   // Receiver holds off while the sender keeps going, so the unit backs up.
   task automatic test_backpressure();
      wait_idle();
      hold_requests++;
      run_programs(40);
      wait_idle();
   endtask

   task automatic test_no_idle(input int count);
      no_idle = 1'b1;
      run_programs(count);
      no_idle = 1'b0;
   endtask

   // response sink with random stalls and a long hold when a test asks for one
   initial begin
      rsp_ready   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 14);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction: %p", rsp_data);
         end else begin
            expected_rsp = predicted_results.pop_front();
            if (rsp_data.status !== expected_rsp.status ||
                rsp_data.next_ip !== expected_rsp.next_ip ||
                rsp_data.out_value !== expected_rsp.out_value ||
                rsp_data.out_valid !== expected_rsp.out_valid ||
                rsp_data.stack_depth !== expected_rsp.stack_depth) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp/got: status %0d/%0d ip %h/%h out %h/%h %b/%b depth %0d/%0d",
                           expected_rsp.status, rsp_data.status,
                           expected_rsp.next_ip, rsp_data.next_ip,
                           expected_rsp.out_value, rsp_data.out_value,
                           expected_rsp.out_valid, rsp_data.out_valid,
                           expected_rsp.stack_depth, rsp_data.stack_depth);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle   = 1'b0;
      foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
      foreach (stack_shadow[i]) stack_shadow[i] = '0;
      foreach (ram_shadow[i]) ram_shadow[i] = '0;
      depth_shadow = 0;
      pc_shadow    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_stack_full();
      load_gprs(32'd3, 32'd100, -32'sd2, 32'd250);
      test_random_programs(550);
      test_backpressure();
      load_gprs(32'h7fff_ffff, 32'h8000_0000, '1, 32'd0);
      test_random_programs(500);
      load_gprs(32'd0, 32'd0, 32'd0, 32'd0);
      test_no_idle(300);
      load_gprs($urandom, $urandom, $urandom_range(255), $urandom);
      test_random_programs(250);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
